### rtl/atb_pkg.sv
// Shared constants and types for the ATA task file builder.
`default_nettype none
package atb_pkg;

  localparam int unsigned AddrBitsDefault = 48;
  localparam int unsigned AddrW = 48;
  localparam int unsigned ReqW = 32;
  localparam int unsigned DivStep = 8;

  typedef enum logic [1:0] {
    MODE_CHS   = 2'd0,
    MODE_LBA28 = 2'd1,
    MODE_LBA48 = 2'd2,
    MODE_ALT48 = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_MODE  = 2'd0,
    REG_SLAVE = 2'd1,
    REG_SPT   = 2'd2,
    REG_HEADS = 2'd3
  } reg_idx_e;

  localparam logic [7:0] CMD_READ      = 8'h20;
  localparam logic [7:0] CMD_WRITE     = 8'h30;
  localparam logic [7:0] CMD_READ_EXT  = 8'h24;
  localparam logic [7:0] CMD_WRITE_EXT = 8'h34;
  localparam logic [7:0] DH_CHS        = 8'ha0;
  localparam logic [7:0] DH_LBA28      = 8'he0;
  localparam logic [7:0] DH_LBA48      = 8'h40;

endpackage
`default_nettype wire

### rtl/atb_div.sv
// Pipelined restoring divider, STEP quotient bits per stage.
`default_nettype none
module atb_div #(
  parameter int unsigned DW   = 48,
  parameter int unsigned VW   = 8,
  parameter int unsigned STEP = 8
) (
  input  wire logic          clk_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [VW-1:0] divisor_i,
  output logic      [DW-1:0] quotient_o,
  output logic      [VW-1:0] remainder_o
);
  localparam int unsigned NS = DW / STEP;

  logic [DW-1:0] w_q [NS+1];
  logic [VW-1:0] r_q [NS+1];
  logic [VW-1:0] d_q [NS+1];

  always_ff @(posedge clk_i) begin
    w_q[0] <= dividend_i;
    r_q[0] <= '0;
    d_q[0] <= divisor_i;
  end

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [DW-1:0] w_d;
    logic [VW-1:0] r_d;

    always_comb begin
      logic [DW-1:0] w;
      logic [VW:0]   r;
      w = w_q[s];
      r = {1'b0, r_q[s]};
      for (int k = 0; k < STEP; k++) begin
        r = {r[VW-1:0], w[DW-1]};
        w = {w[DW-2:0], 1'b0};
        if (r >= {1'b0, d_q[s]}) begin
          r = r - {1'b0, d_q[s]};
          w[0] = 1'b1;
        end
      end
      w_d = w;
      r_d = r[VW-1:0];
    end

    always_ff @(posedge clk_i) begin
      w_q[s+1] <= w_d;
      r_q[s+1] <= r_d;
      d_q[s+1] <= d_q[s];
    end
  end

  assign quotient_o  = w_q[NS];
  assign remainder_o = r_q[NS];
endmodule
`default_nettype wire

### rtl/atb_delay.sv
// Delay line that keeps side data aligned with the divider.
`default_nettype none
module atb_delay #(
  parameter int unsigned W = 8,
  parameter int unsigned N = 2
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic [W-1:0] data_i,
  output logic      [W-1:0] data_o
);
  logic [W-1:0] tap_q [N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) tap_q[i] <= '0;
    end else begin
      tap_q[0] <= data_i;
      for (int i = 1; i < N; i++) tap_q[i] <= tap_q[i-1];
    end
  end

  assign data_o = tap_q[N-1];
endmodule
`default_nettype wire

### rtl/ata_taskfile_builder.sv
// Top level of the ATA task file builder.
// One request is taken every clock (busy never rises) and its task file
// appears on done_o after passing the input capture register, two pipelined
// 48-bit dividers (sectors per track, then heads), 7 register stages each, and
// the output register. The receiver cannot stall the pipeline.
// Configuration is taken at any time but must only change while idle.
`default_nettype none
module ata_taskfile_builder #(
  parameter int unsigned ADDR_BITS = atb_pkg::AddrBitsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        func_i,
  input  wire logic [47:0] block_address_i,
  input  wire logic [31:0] requested_count_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i,
  output logic             done_o,
  output logic [7:0]       command_code_o,
  output logic [7:0]       drive_head_o,
  output logic [7:0]       count_low_o,
  output logic [7:0]       count_high_o,
  output logic [7:0]       addr_byte0_o,
  output logic [7:0]       addr_byte1_o,
  output logic [7:0]       addr_byte2_o,
  output logic [7:0]       addr_byte3_o,
  output logic [7:0]       addr_byte4_o,
  output logic [7:0]       addr_byte5_o,
  output logic [15:0]      granted_count_o
);
  localparam int unsigned AW = atb_pkg::AddrW;
  localparam int unsigned RW = atb_pkg::ReqW;
  localparam int unsigned LAT = AW / atb_pkg::DivStep + 1;
  localparam logic [AW-1:0] LbaMask = {AW{1'b1}} >> (AW - ADDR_BITS);
  localparam int unsigned SW1 = 1 + 1 + AW + RW;
  localparam int unsigned SW2 = SW1 + 8;

  atb_pkg::mode_e mode_q;
  logic           slave_q;
  logic [7:0]     spt_q;
  logic [4:0]     heads_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= atb_pkg::MODE_LBA28;
      slave_q <= 1'b0;
      spt_q   <= 8'd63;
      heads_q <= 5'd16;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (atb_pkg::reg_idx_e'(cfg_index_i))
        atb_pkg::REG_MODE:  mode_q  <= atb_pkg::mode_e'(cfg_data_i[1:0]);
        atb_pkg::REG_SLAVE: slave_q <= cfg_data_i[0];
        atb_pkg::REG_SPT:   spt_q   <= cfg_data_i;
        atb_pkg::REG_HEADS: heads_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  logic [7:0] spt_eff;
  logic [4:0] hc_eff;
  assign spt_eff = (spt_q == 8'd0) ? 8'd1 : spt_q;
  assign hc_eff  = (heads_q == 5'd0) ? 5'd1 : ((heads_q > 5'd16) ? 5'd16 : heads_q);

  // input capture
  logic          in_v_q;
  logic          in_func_q;
  logic [AW-1:0] in_addr_q;
  logic [RW-1:0] in_req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else begin
      in_v_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    in_func_q <= func_i;
    in_addr_q <= block_address_i;
    in_req_q  <= (requested_count_i == '0) ? RW'(1) : requested_count_i;
  end

  logic [AW-1:0] track;
  logic [7:0]    sec_rem;
  atb_div #(.DW(AW), .VW(8), .STEP(atb_pkg::DivStep)) u_div_spt (
    .clk_i      (clk_i),
    .dividend_i (in_addr_q),
    .divisor_i  (spt_eff),
    .quotient_o (track),
    .remainder_o(sec_rem)
  );

  logic [SW1-1:0] side1;
  atb_delay #(.W(SW1), .N(LAT)) u_dly1 (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .data_i({in_v_q, in_func_q, in_addr_q, in_req_q}),
    .data_o(side1)
  );

  logic [AW-1:0] cyl_full;
  logic [4:0]    head_rem;
  atb_div #(.DW(AW), .VW(5), .STEP(atb_pkg::DivStep)) u_div_hc (
    .clk_i      (clk_i),
    .dividend_i (track),
    .divisor_i  (hc_eff),
    .quotient_o (cyl_full),
    .remainder_o(head_rem)
  );

  logic [SW2-1:0] side2;
  atb_delay #(.W(SW2), .N(LAT)) u_dly2 (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .data_i({side1, sec_rem}),
    .data_o(side2)
  );

  logic          s_v;
  logic          s_func;
  logic [AW-1:0] s_addr;
  logic [RW-1:0] s_req;
  logic [7:0]    s_rem;
  assign {s_v, s_func, s_addr, s_req, s_rem} = side2;

  logic [7:0]  cmd_d, dh_d, a0_d, a1_d, a2_d, a3_d, a4_d, a5_d, ch_d;
  logic [15:0] cnt_d;
  logic [7:0]  room;
  logic [AW-1:0] lba48;

  always_comb begin
    room  = spt_eff - s_rem;
    lba48 = s_addr & LbaMask;
    a3_d = 8'h00;
    a4_d = 8'h00;
    a5_d = 8'h00;
    ch_d = 8'h00;
    case (mode_q)
      atb_pkg::MODE_CHS: begin
        cnt_d = (s_req < {24'd0, room}) ? s_req[15:0] : {8'd0, room};
        cmd_d = s_func ? atb_pkg::CMD_WRITE : atb_pkg::CMD_READ;
        dh_d  = atb_pkg::DH_CHS | {3'b000, slave_q, head_rem[3:0]};
        a0_d  = s_rem + 8'd1;
        a1_d  = cyl_full[7:0];
        a2_d  = cyl_full[15:8];
      end
      atb_pkg::MODE_LBA28: begin
        cnt_d = (s_req < 32'hff) ? s_req[15:0] : 16'h00ff;
        cmd_d = s_func ? atb_pkg::CMD_WRITE : atb_pkg::CMD_READ;
        dh_d  = atb_pkg::DH_LBA28 | {3'b000, slave_q, s_addr[27:24]};
        a0_d  = s_addr[7:0];
        a1_d  = s_addr[15:8];
        a2_d  = s_addr[23:16];
      end
      default: begin
        cnt_d = (s_req < 32'hffff) ? s_req[15:0] : 16'hffff;
        cmd_d = s_func ? atb_pkg::CMD_WRITE_EXT : atb_pkg::CMD_READ_EXT;
        dh_d  = atb_pkg::DH_LBA48 | {3'b000, slave_q, 4'h0};
        a0_d  = lba48[7:0];
        a1_d  = lba48[15:8];
        a2_d  = lba48[23:16];
        a3_d  = lba48[31:24];
        a4_d  = lba48[39:32];
        a5_d  = lba48[47:40];
        ch_d  = cnt_d[15:8];
      end
    endcase
  end

  logic done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s_v;
    end
  end

  always_ff @(posedge clk_i) begin
    command_code_o  <= cmd_d;
    drive_head_o    <= dh_d;
    count_low_o     <= cnt_d[7:0];
    count_high_o    <= ch_d;
    addr_byte0_o    <= a0_d;
    addr_byte1_o    <= a1_d;
    addr_byte2_o    <= a2_d;
    addr_byte3_o    <= a3_d;
    addr_byte4_o    <= a4_d;
    addr_byte5_o    <= a5_d;
    granted_count_o <= cnt_d;
  end

  assign done_o = done_q;

  a_cnt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> granted_count_o != 16'd0)
    else $error("zero granted count");

  a_lba28_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && mode_q == atb_pkg::MODE_LBA28 |-> granted_count_o <= 16'd255)
    else $error("lba28 count over 255");

  a_chs_sector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && mode_q == atb_pkg::MODE_CHS |->
      addr_byte0_o != 8'd0 &&
      {8'd0, addr_byte0_o} + granted_count_o <= {8'd0, spt_eff} + 16'd1)
    else $error("chs count runs past track end");

endmodule
`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for the ATA task file builder: random and directed requests.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]  cmd;
    logic [7:0]  dh;
    logic [7:0]  cnt_lo;
    logic [7:0]  cnt_hi;
    logic [47:0] addr;
    logic [15:0] granted;
  } taskfile_t;

  class taskfile_board;
    taskfile_t pending[$];
    int unsigned errors;
    atb_pkg::mode_e mode;
    logic slave;
    logic [7:0] spt;
    logic [4:0] heads;

    function void set_reg(atb_pkg::reg_idx_e idx, logic [7:0] val);
      case (idx)
        atb_pkg::REG_MODE:  mode = atb_pkg::mode_e'(val[1:0]);
        atb_pkg::REG_SLAVE: slave = val[0];
        atb_pkg::REG_SPT:   spt = val;
        atb_pkg::REG_HEADS: heads = val[4:0];
        default: ;
      endcase
    endfunction

    function void note_request(logic wr, logic [47:0] lba, logic [31:0] req);
      taskfile_t t;
      logic [47:0] sp, hc, trk, sec, cyl, room;
      logic [31:0] r;
      r = (req == 0) ? 32'd1 : req;
      t = '0;
      if (mode == atb_pkg::MODE_CHS) begin
        sp = (spt == 0) ? 48'd1 : 48'(spt);
        hc = (heads == 0) ? 48'd1 : (heads > 16) ? 48'd16 : 48'(heads);
        trk = lba / sp;
        sec = lba % sp + 48'd1;
        cyl = (trk / hc) & 48'hffff;
        room = sp - sec + 48'd1;
        t.granted = (48'(r) < room) ? r[15:0] : room[15:0];
        t.cmd = wr ? atb_pkg::CMD_WRITE : atb_pkg::CMD_READ;
        t.dh = atb_pkg::DH_CHS | {3'b0, slave, 4'b0} | {4'b0, 4'(trk % hc)};
        t.addr = {24'b0, cyl[15:0], sec[7:0]};
      end else if (mode == atb_pkg::MODE_LBA28) begin
        t.granted = (r < 32'hff) ? r[15:0] : 16'hff;
        t.cmd = wr ? atb_pkg::CMD_WRITE : atb_pkg::CMD_READ;
        t.dh = atb_pkg::DH_LBA28 | {3'b0, slave, 4'b0} | {4'b0, lba[27:24]};
        t.addr = {24'b0, lba[23:0]};
      end else begin
        t.granted = (r < 32'hffff) ? r[15:0] : 16'hffff;
        t.cmd = wr ? atb_pkg::CMD_WRITE_EXT : atb_pkg::CMD_READ_EXT;
        t.dh = atb_pkg::DH_LBA48 | {3'b0, slave, 4'b0};
        t.addr = lba;
        t.cnt_hi = t.granted[15:8];
      end
      t.cnt_lo = t.granted[7:0];
      pending.push_back(t);
    endfunction

    function void check_taskfile(taskfile_t got);
      taskfile_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected task file %h", got);
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %h actual %h", e, got);
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic start = 0, func = 0, cfg_valid = 0;
  logic [47:0] lba_in = '0;
  logic [31:0] req_in = '0;
  logic [1:0] cfg_idx = '0;
  logic [7:0] cfg_data = '0;
  logic busy, cfg_ready, done;
  wire taskfile_t out_tf;
  taskfile_board board;
  int unsigned idle_pct;
  int unsigned stuck;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  ata_taskfile_builder dut (
    .clk_i(clk), .rst_ni(rst_n), .start(start), .busy(busy),
    .func_i(func), .block_address_i(lba_in), .requested_count_i(req_in),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_index_i(cfg_idx),
    .cfg_data_i(cfg_data), .done_o(done),
    .command_code_o(out_tf.cmd), .drive_head_o(out_tf.dh),
    .count_low_o(out_tf.cnt_lo), .count_high_o(out_tf.cnt_hi),
    .addr_byte0_o(out_tf.addr[7:0]), .addr_byte1_o(out_tf.addr[15:8]),
    .addr_byte2_o(out_tf.addr[23:16]), .addr_byte3_o(out_tf.addr[31:24]),
    .addr_byte4_o(out_tf.addr[39:32]), .addr_byte5_o(out_tf.addr[47:40]),
    .granted_count_o(out_tf.granted)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (done) board.check_taskfile(out_tf);
      if ((start && !busy) || done || (cfg_valid && cfg_ready)) stuck <= 0;
      else stuck <= stuck + 1;
      if (stuck > 20000) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // cfg_valid stays high on return; setup drops it after the last write
  task automatic write_reg(atb_pkg::reg_idx_e idx, logic [7:0] val);
    cfg_idx <= idx;
    cfg_data <= val;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, val);
    @(negedge clk);
  endtask

  // start stays high on return; an idle cycle or drain drops it
  task automatic send_request(logic wr, logic [47:0] lba, logic [31:0] req);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 0;
      @(negedge clk);
    end
    func <= wr;
    lba_in <= lba;
    req_in <= req;
    start <= 1;
    do @(posedge clk); while (busy);
    board.note_request(wr, lba, req);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic setup(atb_pkg::mode_e m, logic sl, logic [7:0] s, logic [4:0] h);
    drain();
    write_reg(atb_pkg::REG_MODE, 8'(m));
    write_reg(atb_pkg::REG_SLAVE, 8'(sl));
    write_reg(atb_pkg::REG_SPT, s);
    write_reg(atb_pkg::REG_HEADS, 8'(h));
    cfg_valid <= 0;
  endtask

  function automatic logic [47:0] rand_lba();
    case ($urandom_range(3))
      0: rand_lba = 48'($urandom_range(20000));
      1: rand_lba = 48'({$urandom, $urandom}) & 48'hfffffff;
      default: rand_lba = 48'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [31:0] rand_req();
    case ($urandom_range(3))
      0: rand_req = $urandom_range(300);
      1: rand_req = $urandom_range(70000);
      default: rand_req = $urandom;
    endcase
  endfunction

  initial begin
    logic [7:0] spt_pick;
    logic [4:0] hd_pick;
    board = new();
    board.set_reg(atb_pkg::REG_MODE, 8'(atb_pkg::MODE_LBA28));
    board.set_reg(atb_pkg::REG_SLAVE, 8'd0);
    board.set_reg(atb_pkg::REG_SPT, 8'd63);
    board.set_reg(atb_pkg::REG_HEADS, 8'd16);
    idle_pct = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    // reset defaults first, then directed corners in each mode
    send_request(1'b0, 48'h0, 32'd0);
    send_request(1'b1, '1, '1);
    setup(atb_pkg::MODE_CHS, 1'b1, 8'd0, 5'd0);
    send_request(1'b0, 48'd5, 32'd3);
    setup(atb_pkg::MODE_CHS, 1'b0, 8'd255, 5'd31);
    send_request(1'b1, 48'd254, 32'd10);
    send_request(1'b0, '1, '1);
    send_request(1'b1, 48'd255, 32'd0);
    setup(atb_pkg::MODE_CHS, 1'b1, 8'd17, 5'd16);
    send_request(1'b0, 48'd16, 32'd1);
    send_request(1'b1, 48'd100, 32'd255);
    setup(atb_pkg::MODE_LBA28, 1'b1, 8'd63, 5'd16);
    send_request(1'b0, 48'hffff_ffff_ffff, 32'd255);
    send_request(1'b1, 48'h0fff_ffff, 32'd256);
    setup(atb_pkg::MODE_LBA48, 1'b0, 8'd1, 5'd1);
    send_request(1'b0, 48'h8000_0000_0001, 32'hffff);
    send_request(1'b1, 48'h1234_5678_9abc, 32'h10000);
    setup(atb_pkg::MODE_ALT48, 1'b1, 8'd1, 5'd1);
    send_request(1'b1, '1, 32'd0);
    send_request(1'b0, 48'h0, 32'hffff_fffe);
    for (int ph = 0; ph < 12; ph++) begin
      idle_pct = (ph < 4) ? 27 : (ph < 8) ? 52 : 0;
      spt_pick = (ph % 3 == 0) ? 8'($urandom) : (ph % 3 == 1) ? 8'd255 : 8'd1;
      hd_pick = (ph % 2) ? 5'($urandom) : 5'd16;
      setup(atb_pkg::mode_e'(ph % 4), 1'($urandom), spt_pick, hd_pick);
      for (int i = 0; i < 90; i++)
        send_request(1'($urandom), rand_lba(), rand_req());
    end
    drain();
    if (board.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

### ata_taskfile_builder.f
rtl/atb_pkg.sv
rtl/atb_div.sv
rtl/atb_delay.sv
rtl/ata_taskfile_builder.sv
sim/tb_top.sv
